// ===== src/rau_pkg.sv =====
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int MAG_W = 64;
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERODEN = 2'd1,
    ST_DIVZERO = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic sum;
    logic gcd_step;
    logic div_start_n;
    logic div_start_d;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

// ===== src/rau_ctrl.sv =====
module rau_ctrl import rau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic done,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        if (sts.bypass) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mul1 = 1'b1;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_start_n = 1'b1;
          state_nxt = S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        if (sts.div_done) begin
          cmd.div_start_d = 1'b1;
          state_nxt = S_DIVD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DIVD: begin
        if (sts.div_done) begin
          cmd.fin = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/rau_dp.sv =====
module rau_dp import rau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [2:0]               in_req_type,
  input  logic signed [31:0]       in_a_num,
  input  logic signed [31:0]       in_a_den,
  input  logic signed [31:0]       in_b_num,
  input  logic signed [31:0]       in_b_den,
  output logic signed [63:0]       out_res_num,
  output logic [61:0]              out_res_den,
  output logic signed [1:0]        out_cmp_result,
  output logic [1:0]               out_status
);

  localparam int OW = OPERAND_WIDTH;

  logic [2:0]         op_r;
  logic signed [OW:0] an_r, ad_r, bn_r, bd_r;
  logic [63:0]        p_r, q_r;
  logic               pn_r, qn_r, dneg_r;
  logic [63:0]        dm_r;
  logic [63:0]        x_r, y_r;
  logic [CNT_W-1:0]   k_r;
  logic [63:0]        nm_r;
  logic               nneg_r;
  logic [63:0]        rem_r, quo_r, dvs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               div_busy_r;
  logic signed [63:0] rnum_r;
  logic [61:0]        rden_r;
  logic signed [1:0]  cmp_r;
  logic [1:0]         st_r;

  function automatic logic signed [OW:0] sx(input logic [31:0] v);
    return {v[OW-1], v[OW-1:0]};
  endfunction

  function automatic logic [OW:0] absv(input logic signed [OW:0] v);
    return v[OW] ? -v : v;
  endfunction

  logic [OW:0] m1a, m1b, m2a, m2b;
  logic        s1, s2;
  logic [63:0] prod1, prod2;
  logic [64:0] diff;
  logic [63:0] rem_sh;
  logic [63:0] gval;
  logic        zden, divz, unk;
  logic signed [OW:0] na_c, nb_c;
  logic signed [64:0] lhs, rhs;

  always_comb begin
    na_c = ad_r[OW] ? -an_r : an_r;
    nb_c = bd_r[OW] ? -bn_r : bn_r;
    m1a = absv(an_r);
    m1b = absv(bd_r);
    s1 = an_r[OW] ^ bd_r[OW];
    m2a = absv(ad_r);
    m2b = absv(bn_r);
    s2 = ad_r[OW] ^ bn_r[OW];
    if (op_r == OP_MUL) begin
      m1b = absv(bn_r);
      s1 = an_r[OW] ^ bn_r[OW];
    end
    if (cmd.mul2) begin
      m1a = absv(ad_r);
      m1b = absv(bd_r);
      s1 = ad_r[OW] ^ bd_r[OW];
    end
    prod1 = 64'(m1a) * 64'(m1b);
    prod2 = 64'(m2a) * 64'(m2b);
    lhs = 65'(na_c) * 65'(m1b);
    rhs = 65'(nb_c) * 65'(m2a);
    diff = {1'b0, p_r} - {1'b0, q_r};
    rem_sh = {rem_r[62:0], quo_r[63]};
    gval = (x_r | y_r) << k_r;
    if (gval == '0) begin
      gval = 64'd1;
    end
    unk = op_r > OP_CMP;
    zden = (ad_r == '0) || (bd_r == '0);
    divz = (op_r == OP_DIV) && (bn_r == '0);
  end

  assign sts.bypass = unk || zden || (op_r == OP_CMP) || divz;
  assign sts.gcd_done = (x_r == '0) || (y_r == '0);
  assign sts.div_done = div_busy_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else begin
      if (cmd.div_start_n || cmd.div_start_d) begin
        div_busy_r <= 1'b1;
      end else if (sts.div_done) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  // payload and sequencing
  logic first_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
    end else begin
      first_r <= cmd.load;
    end
  end

  assign out_res_num = rnum_r;
  assign out_res_den = rden_r;
  assign out_cmp_result = cmp_r;
  assign out_status = st_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_req_type;
      an_r <= sx(in_a_num);
      ad_r <= sx(in_a_den);
      bn_r <= sx(in_b_num);
      bd_r <= sx(in_b_den);
    end
    if (first_r) begin
      rnum_r <= '0;
      rden_r <= '0;
      cmp_r <= '0;
      st_r <= ST_OK;
      if (unk) begin
      end else if (zden) begin
        st_r <= ST_ZERODEN;
      end else if (op_r == OP_CMP) begin
        cmp_r <= (lhs > rhs) ? 2'sb01 : (lhs < rhs) ? 2'sb11 : 2'sb00;
      end else if (divz) begin
        st_r <= ST_DIVZERO;
      end
    end
    if (cmd.mul1) begin
      p_r <= prod1;
      pn_r <= s1 && (prod1 != '0);
      q_r <= prod2;
      qn_r <= (s2 ^ (op_r == OP_SUB)) && (prod2 != '0);
      if (op_r == OP_DIV) begin
        dm_r <= prod2;
        dneg_r <= s2;
      end
    end
    if (cmd.mul2) begin
      if (op_r != OP_DIV) begin
        dm_r <= prod1;
        dneg_r <= s1;
      end
    end
    if (cmd.sum) begin
      if (op_r == OP_ADD || op_r == OP_SUB) begin
        if (pn_r == qn_r) begin
          nm_r <= p_r + q_r;
          nneg_r <= pn_r;
        end else if (!diff[64]) begin
          nm_r <= diff[63:0];
          nneg_r <= pn_r;
        end else begin
          nm_r <= q_r - p_r;
          nneg_r <= qn_r;
        end
        x_r <= (pn_r == qn_r) ? p_r + q_r : (!diff[64] ? diff[63:0] : q_r - p_r);
      end else begin
        nm_r <= p_r;
        nneg_r <= pn_r;
        x_r <= p_r;
      end
      y_r <= dm_r;
      k_r <= '0;
    end
    // binary gcd: drop common factors of two, then halve or subtract-and-halve
    if (cmd.gcd_step) begin
      if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= (x_r - y_r) >> 1;
      end else begin
        y_r <= (y_r - x_r) >> 1;
      end
    end
    if (cmd.div_start_n) begin
      dvs_r <= gval;
      quo_r <= nm_r;
      rem_r <= '0;
      cnt_r <= CNT_W'(64);
    end
    if (cmd.div_start_d) begin
      nm_r <= quo_r;
      quo_r <= dm_r;
      rem_r <= '0;
      cnt_r <= CNT_W'(64);
    end
    if (cmd.div_step) begin
      if (rem_sh >= dvs_r) begin
        rem_r <= rem_sh - dvs_r;
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[62:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.fin) begin
      rnum_r <= ((nneg_r != dneg_r) && nm_r != '0) ? -nm_r : nm_r;
      rden_r <= quo_r[61:0];
      cmp_r <= '0;
      st_r <= ST_OK;
    end
  end

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// From accept to result strobe: compare, zero denominator, divide by zero and
// unknown ops pass from S_MUL1 straight to S_DONE; all other ops run S_MUL1,
// S_MUL2 and S_SUM, then binary GCD steps on the 64-bit magnitudes,
// then two 64-step restoring divisions in one shared divider.
// One item at a time: the next start is taken in the cycle after the strobe,
// so a new item waits for the last one's result; the receiver cannot stall.
// Synchronous active-low reset returns the controller to idle.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  output logic signed [63:0] out_res_num,
  output logic [61:0]        out_res_den,
  output logic signed [1:0]  out_cmp_result,
  output logic [1:0]         out_status
);

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(out_valid), .sts(sts), .cmd(cmd)
  );

  rau_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_req_type(in_req_type), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_cmp_result(out_cmp_result), .out_status(out_status)
  );

endmodule

// ===== src/rau_checker.sv =====
module rau_checker import rau_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [61:0]       out_res_den,
  input logic signed [1:0] out_cmp_result,
  input logic [1:0]        out_status
);

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept without busy");

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe too long");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");

  a_err_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_res_den == '0 && out_cmp_result == '0)
    else $error("error result not cleared");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_res_den(out_res_den), .out_cmp_result(out_cmp_result), .out_status(out_status)
);

// ===== sim/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 400;
  localparam logic [2:0] OP_FIRST_UNKNOWN = 3'd5;
  localparam logic [2:0] OP_LAST_CODE     = 3'd7;
  localparam logic signed [31:0] MAX_POS = 32'sh7fffffff;
  localparam logic signed [31:0] MOST_NEG = 32'sh80000000;

  typedef struct {
    logic signed [63:0] num;
    logic [61:0]        den;
    logic signed [1:0]  cmp;
    logic [1:0]         status;
  } frac_res_t;

  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } signmag_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_req_type;
  logic signed [31:0] in_a_num, in_a_den, in_b_num, in_b_den;
  logic out_valid;
  logic signed [63:0] out_res_num;
  logic [61:0] out_res_den;
  logic signed [1:0] out_cmp_result;
  logic [1:0] out_status;

  frac_res_t pending_q[$];
  int  errors;
  int  idle_pct;
  int  quiet_cycles;

  rational_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den), .out_valid(out_valid),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_cmp_result(out_cmp_result), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mag_of(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic signmag_t smul(longint x, longint y);
    signmag_t r;
    r.mag = mag_of(x) * mag_of(y);
    r.neg = ((x < 0) != (y < 0)) && (r.mag != 0);
    return r;
  endfunction

  function automatic signmag_t sadd(signmag_t p, signmag_t q);
    signmag_t r;
    if (p.neg == q.neg) begin
      r.mag = p.mag + q.mag;
      r.neg = p.neg;
    end else if (p.mag >= q.mag) begin
      r.mag = p.mag - q.mag;
      r.neg = p.neg;
    end else begin
      r.mag = q.mag - p.mag;
      r.neg = q.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic frac_res_t fraction_result(logic [2:0] op, logic signed [31:0] an32,
                                                logic signed [31:0] ad32,
                                                logic signed [31:0] bn32,
                                                logic signed [31:0] bd32);
    frac_res_t r;
    longint an, ad, bn, bd, na, nb, lhs, rhs;
    signmag_t n, d, p, q;
    logic [63:0] g, x, y, t, nm, dm;
    an = an32; ad = ad32; bn = bn32; bd = bd32;
    r.num = '0; r.den = '0; r.cmp = '0; r.status = ST_OK;
    if (op > OP_CMP) begin
      r.status = ST_OK;
    end else if (ad == 0 || bd == 0) begin
      r.status = ST_ZERODEN;
    end else if (op == OP_CMP) begin
      na = (ad < 0) ? -an : an;
      nb = (bd < 0) ? -bn : bn;
      lhs = na * longint'(mag_of(bd));
      rhs = nb * longint'(mag_of(ad));
      if (lhs > rhs) r.cmp = 2'sd1;
      else if (lhs < rhs) r.cmp = -2'sd1;
    end else if (op == OP_DIV && bn == 0) begin
      r.status = ST_DIVZERO;
    end else begin
      if (op == OP_ADD || op == OP_SUB) begin
        p = smul(an, bd);
        q = smul(ad, bn);
        if (op == OP_SUB && q.mag != 0) q.neg = !q.neg;
        n = sadd(p, q);
        d = smul(ad, bd);
      end else if (op == OP_MUL) begin
        n = smul(an, bn);
        d = smul(ad, bd);
      end else begin
        n = smul(an, bd);
        d = smul(ad, bn);
      end
      x = n.mag; y = d.mag;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      g = (x == 0) ? 64'd1 : x;
      nm = n.mag / g;
      dm = d.mag / g;
      r.num = ((n.neg != d.neg) && nm != 0) ? -nm : nm;
      r.den = dm[61:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    frac_res_t e;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result num=%0d den=%0d cmp=%0d st=%0d", $time,
                   out_res_num, out_res_den, out_cmp_result, out_status);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (out_res_num !== e.num) begin
            $display("%0t: res_num exp %0d got %0d", $time, e.num, out_res_num);
            errors++;
          end
          if (out_res_den !== e.den) begin
            $display("%0t: res_den exp %0d got %0d", $time, e.den, out_res_den);
            errors++;
          end
          if (out_cmp_result !== e.cmp) begin
            $display("%0t: cmp_result exp %0d got %0d", $time, e.cmp, out_cmp_result);
            errors++;
          end
          if (out_status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
            errors++;
          end
        end
      end
      if (start && !busy)
        pending_q.push_back(fraction_result(in_req_type, in_a_num, in_a_den,
                                            in_b_num, in_b_den));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic [2:0] op, logic signed [31:0] an, logic signed [31:0] ad,
                           logic signed [31:0] bn, logic signed [31:0] bd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= op;
    in_a_num    <= an;
    in_a_den    <= ad;
    in_b_num    <= bn;
    in_b_den    <= bd;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [31:0] rand_word();
    return $signed($urandom());
  endfunction

  task automatic test_special_cases();
    send_item(OP_ADD, 32'sd3, 32'sd0, 32'sd1, 32'sd2);
    send_item(OP_DIV, 32'sd3, 32'sd5, 32'sd1, 32'sd0);
    send_item(OP_CMP, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_DIV, 32'sd3, 32'sd5, 32'sd0, 32'sd7);
    send_item(OP_MUL, 32'sd0, -32'sd9, 32'sd4, 32'sd7);
    send_item(OP_SUB, 32'sd2, 32'sd3, 32'sd4, 32'sd6);
    send_item(OP_ADD, 32'sd1, -32'sd2, -32'sd1, 32'sd3);
    for (logic [3:0] op = 4'(OP_FIRST_UNKNOWN); op <= 4'(OP_LAST_CODE); op++)
      send_item(op[2:0], 32'sd1, 32'sd2, 32'sd3, 32'sd4);
  endtask

  task automatic test_extremes();
    send_item(OP_CMP, MAX_POS, 32'sd1, -MAX_POS, 32'sd1);
    send_item(OP_CMP, -MAX_POS, MAX_POS, MAX_POS, -MAX_POS);
    send_item(OP_CMP, MOST_NEG, 32'sd1, MOST_NEG, MOST_NEG);
    send_item(OP_CMP, MAX_POS, -32'sd1, MAX_POS, MAX_POS);
    send_item(OP_MUL, MAX_POS, MAX_POS - 1, MAX_POS - 1, MAX_POS);
    send_item(OP_DIV, -MAX_POS, MAX_POS, MAX_POS, -MAX_POS);
    send_item(OP_ADD, MAX_POS, MAX_POS, -MAX_POS, -MAX_POS);
    send_item(OP_SUB, MAX_POS, -MAX_POS, MAX_POS, MAX_POS);
    send_item(OP_MUL, MOST_NEG, 32'sh40000000, 32'sd1, 32'sd1);
    send_item(OP_DIV, MOST_NEG, MOST_NEG, -32'sd3, 32'sd3);
  endtask

  // arithmetic operands as small ratios scaled by a large or small factor keep the gcd short
  task automatic test_random(int count);
    int sel, pa, qa, pb, qb;
    int unsigned ma, mb;
    logic [2:0] op;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        send_item(OP_CMP, rand_word(), rand_word(), rand_word(), rand_word());
      end else if (sel < 19) begin
        send_item(3'($urandom_range(OP_LAST_CODE, OP_FIRST_UNKNOWN)), rand_word(),
                  rand_word(), rand_word(), rand_word());
      end else if (sel < 24) begin
        if ($urandom_range(1)) send_item(3'($urandom_range(OP_CMP)), rand_word(), 32'sd0,
                                         rand_word(), rand_word());
        else send_item(3'($urandom_range(OP_CMP)), rand_word(), rand_word(),
                       rand_word(), 32'sd0);
      end else begin
        op = 3'($urandom_range(OP_CMP));
        pa = int'($urandom_range(30)) - 15;
        pb = int'($urandom_range(30)) - 15;
        qa = int'($urandom_range(1, 15)) * ($urandom_range(1) ? 1 : -1);
        qb = int'($urandom_range(1, 15)) * ($urandom_range(1) ? 1 : -1);
        if (op == OP_DIV && sel < 27) pb = 0;
        ma = $urandom_range(1) ? $urandom_range(1, 143165576) : $urandom_range(1, 8);
        mb = $urandom_range(1) ? $urandom_range(1, 143165576) : $urandom_range(1, 8);
        send_item(op, pa * int'(ma), qa * int'(ma), pb * int'(mb), qb * int'(mb));
      end
    end
  endtask

  initial begin
    errors       = 0;
    idle_pct     = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req_type  = OP_ADD;
    in_a_num     = '0;
    in_a_den     = '0;
    in_b_num     = '0;
    in_b_den     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_extremes();
    idle_pct = 0;
    test_random(450);
    idle_pct = 48;
    test_random(420);
    idle_pct = 33;
    test_random(420);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
